// ===== hdl/ltfp_pkg.sv =====
// ltfp_pkg: shared types and constants for the link tuple filter parser
// used by ltfp_front, ltfp_fifo, ltfp_back and link_tuple_filter_parser
package ltfp_pkg;

	localparam int ID_DEPTH = 32;
	localparam int IDX_W    = (ID_DEPTH > 1) ? $clog2(ID_DEPTH) : 1;
	localparam int CNT_W    = $clog2(ID_DEPTH + 1);
	localparam int Q_DEPTH  = 4;
	localparam int QPTR_W   = $clog2(Q_DEPTH);
	localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] CH_OPEN   = 8'h28;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;

	typedef enum logic [2:0] {
		PH_OUTSIDE,
		PH_ID,
		PH_NS,
		PH_SKIPQ,
		PH_TITLE,
		PH_ESC
	} phase_t;

	typedef enum logic [1:0] {
		NS_EMPTY,
		NS_MATCH,
		NS_OTHER
	} ns_t;

	typedef enum logic [1:0] {
		CMD_WR,
		CMD_BYTE,
		CMD_RUN
	} cmd_kind_t;

	typedef enum logic {
		BK_CMD,
		BK_RUN
	} back_state_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [7:0]        data;
		logic [CNT_W-1:0]  idx;
	} cmd_t;

endpackage

// ===== hdl/ltfp_front.sv =====
// ltfp_front: accepts input bytes, tracks tuple phase and namespace match,
// and issues id writes, id runs and single bytes as commands; uses ltfp_pkg
module ltfp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                q_full,
	output logic                q_push,
	output ltfp_pkg::cmd_t      q_cmd
);

	ltfp_pkg::phase_t                 phase_q, phase_d;
	ltfp_pkg::ns_t                    ns_q, ns_d;
	logic [ltfp_pkg::CNT_W-1:0]       id_count_q, id_count_d;
	logic                             keep_q, keep_d;
	logic                             accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	// next state
	always_comb begin
		phase_d    = phase_q;
		ns_d       = ns_q;
		id_count_d = id_count_q;
		keep_d     = keep_q;
		case (phase_q)
			ltfp_pkg::PH_OUTSIDE: begin
				if (in_byte == ltfp_pkg::CH_OPEN) begin
					phase_d    = ltfp_pkg::PH_ID;
					id_count_d = '0;
				end
			end
			ltfp_pkg::PH_ID: begin
				if (in_byte == ltfp_pkg::CH_COMMA) begin
					phase_d = ltfp_pkg::PH_NS;
					ns_d    = ltfp_pkg::NS_EMPTY;
				end else if (id_count_q < ltfp_pkg::CNT_W'(ltfp_pkg::ID_DEPTH)) begin
					id_count_d = id_count_q + 1'b1;
				end
			end
			ltfp_pkg::PH_NS: begin
				if (in_byte == ltfp_pkg::CH_COMMA) begin
					phase_d = ltfp_pkg::PH_SKIPQ;
					keep_d  = (ns_q == ltfp_pkg::NS_MATCH);
				end else if (ns_q == ltfp_pkg::NS_EMPTY && in_byte == ltfp_pkg::CH_ZERO) begin
					ns_d = ltfp_pkg::NS_MATCH;
				end else begin
					ns_d = ltfp_pkg::NS_OTHER;
				end
			end
			ltfp_pkg::PH_SKIPQ: begin
				phase_d = ltfp_pkg::PH_TITLE;
			end
			ltfp_pkg::PH_TITLE: begin
				if (in_byte == ltfp_pkg::CH_BSLASH) begin
					phase_d = ltfp_pkg::PH_ESC;
				end else if (in_byte == ltfp_pkg::CH_QUOTE) begin
					phase_d = ltfp_pkg::PH_OUTSIDE;
				end
			end
			ltfp_pkg::PH_ESC: begin
				phase_d = ltfp_pkg::PH_TITLE;
			end
			default: begin
				phase_d = ltfp_pkg::PH_OUTSIDE;
			end
		endcase
	end

	// command issue
	always_comb begin
		q_push      = 1'b0;
		q_cmd.kind  = ltfp_pkg::CMD_BYTE;
		q_cmd.data  = in_byte;
		q_cmd.idx   = id_count_q;
		case (phase_q)
			ltfp_pkg::PH_ID: begin
				if (in_byte != ltfp_pkg::CH_COMMA &&
				    id_count_q < ltfp_pkg::CNT_W'(ltfp_pkg::ID_DEPTH)) begin
					q_push     = accept;
					q_cmd.kind = ltfp_pkg::CMD_WR;
				end
			end
			ltfp_pkg::PH_NS: begin
				if (in_byte == ltfp_pkg::CH_COMMA && ns_q == ltfp_pkg::NS_MATCH) begin
					q_push     = accept;
					q_cmd.kind = ltfp_pkg::CMD_RUN;
				end
			end
			ltfp_pkg::PH_TITLE: begin
				if (in_byte == ltfp_pkg::CH_QUOTE) begin
					q_push     = accept && keep_q;
					q_cmd.data = ltfp_pkg::CH_NL;
				end else if (in_byte != ltfp_pkg::CH_BSLASH) begin
					q_push = accept && keep_q;
				end
			end
			ltfp_pkg::PH_ESC: begin
				q_push = accept && keep_q;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ltfp_pkg::PH_OUTSIDE;
			ns_q       <= ltfp_pkg::NS_EMPTY;
			id_count_q <= '0;
			keep_q     <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			ns_q       <= ns_d;
			id_count_q <= id_count_d;
			keep_q     <= keep_d;
		end
	end

endmodule

// ===== hdl/ltfp_fifo.sv =====
// ltfp_fifo: short command queue between front and back
// uses cmd_t and queue constants from ltfp_pkg
module ltfp_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ltfp_pkg::cmd_t      push_cmd,
	input  logic                pop,
	output ltfp_pkg::cmd_t      head_cmd,
	output logic                full,
	output logic                empty
);

	ltfp_pkg::cmd_t                   slot_q [ltfp_pkg::Q_DEPTH];
	logic [ltfp_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [ltfp_pkg::QCNT_W-1:0]      count_q;

	assign full     = (count_q == ltfp_pkg::QCNT_W'(ltfp_pkg::Q_DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/ltfp_back.sv =====
// ltfp_back: executes queued commands, owns the id memory and the output register
// uses cmd_t, back_state_t and constants from ltfp_pkg
module ltfp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  ltfp_pkg::cmd_t      q_cmd,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                run_last
);

	ltfp_pkg::back_state_t            state_q, state_d;
	logic [7:0]                       id_mem [ltfp_pkg::ID_DEPTH];
	logic [7:0]                       rdata_q;
	logic [ltfp_pkg::CNT_W-1:0]       idx_q, cnt_q;
	logic                             out_valid_q, sel_mem_q, last_q;
	logic [7:0]                       lit_q;
	logic                             advance, load, ld_sel_mem, ld_last, rd_en, we, run_start;
	logic [7:0]                       ld_lit;

	assign advance   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_byte  = sel_mem_q ? rdata_q : lit_q;
	assign run_last  = last_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ltfp_pkg::BK_CMD: begin
				if (!q_empty && q_cmd.kind == ltfp_pkg::CMD_RUN) begin
					state_d = ltfp_pkg::BK_RUN;
				end
			end
			ltfp_pkg::BK_RUN: begin
				if (advance && idx_q == cnt_q) begin
					state_d = ltfp_pkg::BK_CMD;
				end
			end
			default: begin
				state_d = ltfp_pkg::BK_CMD;
			end
		endcase
	end

	// outputs
	always_comb begin
		q_pop      = 1'b0;
		we         = 1'b0;
		run_start  = 1'b0;
		load       = 1'b0;
		ld_sel_mem = 1'b0;
		ld_lit     = q_cmd.data;
		ld_last    = 1'b0;
		rd_en      = 1'b0;
		case (state_q)
			ltfp_pkg::BK_CMD: begin
				if (!q_empty) begin
					case (q_cmd.kind)
						ltfp_pkg::CMD_WR: begin
							q_pop = 1'b1;
							we    = 1'b1;
						end
						ltfp_pkg::CMD_BYTE: begin
							q_pop   = advance;
							load    = advance;
							ld_last = 1'b1;
						end
						ltfp_pkg::CMD_RUN: begin
							q_pop     = 1'b1;
							run_start = 1'b1;
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			ltfp_pkg::BK_RUN: begin
				if (advance) begin
					load = 1'b1;
					if (idx_q == cnt_q) begin
						ld_lit  = ltfp_pkg::CH_SPACE;
						ld_last = 1'b1;
					end else begin
						ld_sel_mem = 1'b1;
						rd_en      = 1'b1;
					end
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			id_mem[q_cmd.idx[ltfp_pkg::IDX_W-1:0]] <= q_cmd.data;
		end
		if (rd_en) begin
			rdata_q <= id_mem[idx_q[ltfp_pkg::IDX_W-1:0]];
		end
		if (load) begin
			sel_mem_q <= ld_sel_mem;
			lit_q     <= ld_lit;
			last_q    <= ld_last;
		end
		if (run_start) begin
			cnt_q <= q_cmd.idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ltfp_pkg::BK_CMD;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (run_start) begin
				idx_q <= '0;
			end else if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

// ===== hdl/link_tuple_filter_parser.sv =====
// link_tuple_filter_parser: top level joining front, command queue and back
// depends on ltfp_pkg, ltfp_front, ltfp_fifo and ltfp_back
//
// Input bytes are taken one per cycle while the four-entry command queue has room.
// Id bytes, title bytes and the closing newline each become one command for the
// back part; a kept tuple's id run starts with a run command, then sends each stored
// id byte and a space while taking no command, so the queue can fill and stall input.
// Output data comes from a single output register, so a result waits there
// without blocking input until the queue is full. Id bytes past 32 are dropped.
module link_tuple_filter_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        run_last
);

	ltfp_pkg::cmd_t  push_cmd, head_cmd;
	logic            q_push, q_pop, q_full, q_empty;

	ltfp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	ltfp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	ltfp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (head_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into a full queue");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command popped from an empty queue");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue reports full and empty at once");

	a_input_stall: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !in_ready)
		else $error("input taken while queue is full");
`endif

endmodule
